// ===== rtl/scla_pkg.sv =====
// ----------------------------------------------------------------------------
// scla_pkg
// Shared types and constants for the serial command line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package scla_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int STORE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(STORE_DEPTH);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [7:0] CH_CANCEL = 8'd24;
    localparam logic [7:0] CH_QUERY  = 8'd63;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_S      = 8'd83;

    typedef enum logic [2:0] {
        KIND_CAPTURE = 3'd0,
        KIND_HALT    = 3'd1,
        KIND_STATUS  = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_DATA    = 3'd4,
        KIND_INSTANT = 3'd5
    } kind_t;

    // one queued job: either a single result or a line to stream from the store
    typedef struct packed {
        logic             stream;
        kind_t            kind;
        logic [7:0]       data;
        logic             empty;
        logic [IDX_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/serial_command_line_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_assembler_unit
// Builds command lines from serial bytes, with raw capture, halt and status
// requests, instant queries and long line discard.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | tdata: rx_byte, system_halted, query_queue_full
//  m_       | out       | tdata: data_byte, line_empty; tuser: kind; tlast
//  cfg_     | in        | cfg_data: capture_enable, always ready
//
//  a byte with at most one result is taken while the job queue has room; its
//  result sits in the output register while further bytes come in through
//  the job queue. a completed line is read from the line store, whose read
//  is registered, one character at a time through a fetch and a send state,
//  and no byte is taken until its last character has been loaded into the
//  output register. reset clears count, discard mark, queue and output; the
//  line store is not cleared. either side may stall at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_line_assembler_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] rx_byte, [8] system_halted, [9] query_queue_full
    input  wire logic [scla_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] data_byte, [8] line_empty
    output logic [scla_pkg::M_TDATA_W-1:0]      m_tdata,
    // [2:0] kind
    output logic [2:0]                          m_tuser,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data
);
    import scla_pkg::*;

    logic    q_push;
    cmd_t    q_cmd;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    cmd_t    q_head;
    logic    stream_done;
    mem_wr_t mem_wr;

    scla_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_cmd       (q_cmd),
        .q_full      (q_full),
        .stream_done (stream_done),
        .mem_wr      (mem_wr)
    );

    scla_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    scla_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mem_wr      (mem_wr),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .stream_done (stream_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/scla_queue.sv =====
// ----------------------------------------------------------------------------
// scla_queue
// Two-entry job queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scla_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire scla_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output scla_pkg::cmd_t     head
);
    import scla_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;

    assign full  = (level_reg == 2'd2);
    assign valid = (level_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            level_next = level_reg + 2'd1;
        end else if (pop && !push) begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scla_front.sv =====
// ----------------------------------------------------------------------------
// scla_front
// Accepts serial bytes, tracks the line count and discard mark, writes the
// line store and queues the jobs each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module scla_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [scla_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data,
    output logic                                q_push,
    output scla_pkg::cmd_t                      q_cmd,
    input  wire logic                           q_full,
    input  wire logic                           stream_done,
    output scla_pkg::mem_wr_t                   mem_wr
);
    import scla_pkg::*;

    logic             capture_reg;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             discard_reg, discard_next;
    logic             pending_reg, pending_next;
    logic [7:0]       e0_reg, e0_next;
    logic [7:0]       e1_reg, e1_next;

    logic [7:0] rx_byte;
    logic       halted;
    logic       qfull;
    logic       accept;

    assign rx_byte   = s_tdata[7:0];
    assign halted    = s_tdata[8];
    assign qfull     = s_tdata[9];
    assign cfg_ready = 1'b1;
    // no new byte while a line is being read out of the store
    assign s_tready  = !q_full && !pending_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        count_next   = count_reg;
        discard_next = discard_reg;
        pending_next = pending_reg;
        e0_next      = e0_reg;
        e1_next      = e1_reg;
        q_push       = 1'b0;
        q_cmd        = '0;
        mem_wr.en    = accept;
        mem_wr.addr  = count_reg;
        mem_wr.data  = rx_byte;

        if (stream_done) begin
            pending_next = 1'b0;
        end

        if (accept) begin
            if (count_reg == IDX_W'(0)) begin
                e0_next = rx_byte;
            end
            if (count_reg == IDX_W'(1)) begin
                e1_next = rx_byte;
            end

            if (capture_reg) begin
                q_push     = 1'b1;
                q_cmd.kind = KIND_CAPTURE;
                q_cmd.data = rx_byte;
            end else if (rx_byte == CH_CANCEL) begin
                q_push       = !halted;
                q_cmd.kind   = KIND_HALT;
                discard_next = 1'b0;
                count_next   = '0;
            end else if (rx_byte == CH_QUERY) begin
                q_push     = !qfull;
                q_cmd.kind = KIND_STATUS;
            end else if (discard_reg) begin
                if (rx_byte == CH_LF) begin
                    discard_next = 1'b0;
                end
            end else if (count_reg >= IDX_W'(LINE_CAPACITY - 1)) begin
                // limit reached: even a newline starts discard here
                discard_next = 1'b1;
                count_next   = '0;
                q_push       = 1'b1;
                q_cmd.kind   = KIND_LONG;
            end else if (rx_byte == CH_LF) begin
                if (count_reg == IDX_W'(2) && e0_reg == CH_DOLLAR &&
                    (e1_reg == CH_I || e1_reg == CH_S)) begin
                    q_push     = !qfull;
                    q_cmd.kind = KIND_INSTANT;
                    q_cmd.data = e1_reg;
                end else if (count_reg == IDX_W'(0)) begin
                    q_push      = 1'b1;
                    q_cmd.kind  = KIND_DATA;
                    q_cmd.empty = 1'b1;
                end else begin
                    q_push       = 1'b1;
                    q_cmd.stream = 1'b1;
                    q_cmd.kind   = KIND_DATA;
                    q_cmd.count  = count_reg;
                    pending_next = 1'b1;
                end
                count_next = '0;
            end else if (rx_byte == CH_CR) begin
                count_next = count_reg;
            end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
                if (count_reg != IDX_W'(0)) begin
                    count_next = count_reg - IDX_W'(1);
                end
            end else begin
                count_next = count_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_reg <= 1'b0;
            count_reg   <= '0;
            discard_reg <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capture_reg <= cfg_data;
            end
            count_reg   <= count_next;
            discard_reg <= discard_next;
            pending_reg <= pending_next;
        end
    end

    // copies of the first two line characters for the instant query check
    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

`default_nettype wire

// ===== rtl/scla_back.sv =====
// ----------------------------------------------------------------------------
// scla_back
// Holds the line store and turns queued jobs into results on the output
// register, reading stored lines out one character at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module scla_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire scla_pkg::mem_wr_t              mem_wr,
    input  wire logic                           q_valid,
    input  wire scla_pkg::cmd_t                 q_head,
    output logic                                q_pop,
    output logic                                stream_done,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [scla_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [2:0]                          m_tuser,
    output logic                                m_tlast
);
    import scla_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    logic [7:0]       mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic             valid_reg, valid_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       data_reg, data_next;
    logic             empty_reg, empty_next;
    logic             last_reg, last_next;

    logic             out_free;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 9){1'b0}}, empty_reg, data_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        data_next   = data_reg;
        empty_next  = empty_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        stream_done = 1'b0;

        if (m_tready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_head.stream) begin
                        q_pop      = 1'b1;
                        idx_next   = '0;
                        cnt_next   = q_head.count;
                        state_next = ST_FETCH;
                    end else if (out_free) begin
                        q_pop      = 1'b1;
                        valid_next = 1'b1;
                        kind_next  = q_head.kind;
                        data_next  = q_head.data;
                        empty_next = q_head.empty;
                        last_next  = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                // rd_data_reg takes the read data for idx_reg at the end of this state
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = KIND_DATA;
                    data_next  = rd_data_reg;
                    empty_next = 1'b0;
                    last_next  = (idx_reg == cnt_reg - IDX_W'(1));
                    if (idx_reg == cnt_reg - IDX_W'(1)) begin
                        stream_done = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        empty_reg <= empty_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= mem[idx_reg];
    end

endmodule

`default_nettype wire

// ===== bench/serial_command_line_assembler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_assembler_unit_tb
// Streams serial bytes into the line assembler, directed cases first and then
// random command lines, noise and raw capture bursts. A scoreboard models the
// line store, count and discard mark, and checks every result in order.
// ----------------------------------------------------------------------------
module serial_command_line_assembler_unit_tb;
    import scla_pkg::*;

    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 160;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_MODE = 160;
    localparam int CAPTURE_ITEMS  = 16;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       empty;
        logic       last;
    } line_result_t;

    class line_scoreboard;
        logic [7:0]       line_mem [STORE_DEPTH];
        logic [IDX_W-1:0] char_count;
        bit               discarding;
        bit               capture_on;
        line_result_t     pending_q[$];
        int               failures;

        function new();
            char_count = '0;
            discarding = 1'b0;
            capture_on = 1'b0;
            failures   = 0;
            foreach (line_mem[i]) line_mem[i] = 8'h00;
        endfunction

        // work out the results one accepted request causes
        function void note_byte(logic [7:0] b, bit halted, bit full);
            line_result_t batch[$];
            line_result_t r;
            r = '0;
            line_mem[char_count] = b;
            if (capture_on) begin
                r.kind = KIND_CAPTURE;
                r.data = b;
                batch.insert(batch.size(), r);
            end else if (b == CH_CANCEL) begin
                if (!halted) begin
                    r.kind = KIND_HALT;
                    batch.insert(batch.size(), r);
                end
                discarding = 1'b0;
                char_count = '0;
            end else if (b == CH_QUERY) begin
                if (!full) begin
                    r.kind = KIND_STATUS;
                    batch.insert(batch.size(), r);
                end
            end else if (discarding) begin
                if (b == CH_LF) discarding = 1'b0;
            end else if (char_count >= LINE_CAPACITY - 1) begin
                // line limit hit, even by a newline
                discarding = 1'b1;
                char_count = '0;
                r.kind = KIND_LONG;
                batch.insert(batch.size(), r);
            end else if (b == CH_LF) begin
                if (char_count == 2 && line_mem[0] == CH_DOLLAR &&
                    (line_mem[1] == CH_I || line_mem[1] == CH_S)) begin
                    if (!full) begin
                        r.kind = KIND_INSTANT;
                        r.data = line_mem[1];
                        batch.insert(batch.size(), r);
                    end
                end else if (char_count == 0) begin
                    r.kind  = KIND_DATA;
                    r.empty = 1'b1;
                    batch.insert(batch.size(), r);
                end else begin
                    for (int i = 0; i < char_count; i++) begin
                        r.kind = KIND_DATA;
                        r.data = line_mem[i];
                        batch.insert(batch.size(), r);
                    end
                end
                char_count = '0;
            end else if (b == CH_CR) begin
                // carriage return is dropped
            end else if (b == CH_BS || b == CH_DEL) begin
                if (char_count != 0) char_count--;
            end else begin
                char_count++;
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) pending_q.insert(pending_q.size(), batch[i]);
        endfunction

        function void check_result(logic [2:0] got_kind, logic [7:0] got_data,
                                   logic got_empty, logic got_last);
            line_result_t want;
            if (pending_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: kind %0d data %02h empty %0b last %0b",
                             got_kind, got_data, got_empty, got_last);
                return;
            end
            want = pending_q[0];
            pending_q.delete(0);
            if (got_kind !== want.kind || got_data !== want.data ||
                got_empty !== want.empty || got_last !== want.last) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"result mismatch: expected kind %0d data %02h empty %0b ",
                              "last %0b, got kind %0d data %02h empty %0b last %0b"},
                             want.kind, want.data, want.empty, want.last,
                             got_kind, got_data, got_empty, got_last);
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;

    line_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    bit             hold_req      = 1'b0;
    int             bytes_sent    = 0;
    int             idle_cycles   = 0;

    serial_command_line_assembler_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one process sees every handshake, so a request is noted before its result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.capture_on = cfg_data;
            if (s_tvalid && s_tready) sb.note_byte(s_tdata[7:0], s_tdata[8], s_tdata[9]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, or one long hold-off on demand
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic bit random_flag();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] random_text();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 126)); while (c == CH_QUERY);
        return c;
    endfunction

    // mostly text, with edits, queries, cancels and odd bytes mixed in
    function automatic logic [7:0] line_char();
        case ($urandom_range(0, 19))
            0:       return CH_BS;
            1:       return CH_DEL;
            2:       return CH_CR;
            3:       return CH_QUERY;
            4:       return ($urandom_range(0, 3) == 0) ? CH_CANCEL : 8'($urandom_range(128, 255));
            5:       return 8'h00;
            default: return random_text();
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit halted, input bit full);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, full, halted, b};
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capture(input bit value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_line();
        int         pick;
        int         len;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // instant query, now and then with a wrong letter
            send_byte(CH_DOLLAR, random_flag(), random_flag());
            if ($urandom_range(0, 9) == 0) c = random_text();
            else c = random_flag() ? CH_I : CH_S;
            send_byte(c, random_flag(), random_flag());
            send_byte(CH_LF, random_flag(), random_flag());
        end else if (pick < 16) begin
            // lines around the capacity limit
            case ($urandom_range(0, 3))
                0:       len = LINE_CAPACITY - 2;
                1:       len = LINE_CAPACITY - 1;
                2:       len = LINE_CAPACITY;
                default: len = LINE_CAPACITY + $urandom_range(1, 8);
            endcase
            repeat (len) send_byte(random_text(), random_flag(), random_flag());
            send_byte(CH_LF, random_flag(), random_flag());
        end else if (pick < 24) begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(0, 255)), random_flag(), random_flag());
        end else begin
            len = $urandom_range(0, 10);
            repeat (len) send_byte(line_char(), random_flag(), random_flag());
            send_byte(CH_LF, random_flag(), random_flag());
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 47;
        write_capture(1'b0);

        // empty line, instant queries with and without room
        send_byte(CH_LF, 1'b0, 1'b0);
        send_byte(CH_DOLLAR, 1'b0, 1'b0);
        send_byte(CH_I, 1'b0, 1'b0);
        send_byte(CH_LF, 1'b1, 1'b0);
        send_byte(CH_DOLLAR, 1'b1, 1'b1);
        send_byte(CH_S, 1'b0, 1'b1);
        send_byte(CH_LF, 1'b0, 1'b1);
        // status query, cancel with and without halt
        send_byte(CH_QUERY, 1'b0, 1'b0);
        send_byte(CH_QUERY, 1'b1, 1'b1);
        send_byte(CH_CANCEL, 1'b0, 1'b1);
        send_byte(CH_CANCEL, 1'b1, 1'b0);
        // erase on an empty line
        send_byte(CH_BS, 1'b0, 1'b0);
        send_byte(CH_DEL, 1'b1, 1'b1);
        // NUL and all-ones bytes, edits and a carriage return inside a line
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(CH_BS, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b1, 1'b1);
        send_byte(CH_DEL, 1'b0, 1'b0);
        send_byte(CH_CR, 1'b0, 1'b0);
        send_byte(CH_LF, 1'b0, 1'b0);

        for (int mode = 0; mode < 3; mode++) begin : idle_mode
            int  phase_start;
            bit  paused;
            case (mode)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            wait_for_drain();
            write_capture(1'b1);
            repeat (CAPTURE_ITEMS)
                send_byte(8'($urandom_range(0, 255)), random_flag(), random_flag());
            wait_for_drain();
            write_capture(1'b0);

            // receiver holds off while lines keep coming
            if (mode == 2) hold_req = 1'b1;
            phase_start = bytes_sent;
            paused = 1'b0;
            while (bytes_sent - phase_start < ITEMS_PER_MODE - CAPTURE_ITEMS) begin
                send_random_line();
                if (mode == 1 && !paused && bytes_sent - phase_start > 60) begin
                    wait_for_drain();
                    paused = 1'b1;
                end
            end
        end

        wait_for_drain();
        if (sb.failures == 0 && sb.pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
